### rtl/core/assert_macros.svh
// assertion macros used by bdd_node_hash_table_unit, the only rtl file of the node hash table that includes them
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define BNHT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// condition must never be seen outside reset
`define BNHT_NEVER(lbl, clk, rst_n, cond) \
  `BNHT_ASSERT(lbl, clk, rst_n, !(cond))

`endif

### rtl/core/bnht_pkg.sv
// types and constants of the node hash table
// used by bnht_store and bdd_node_hash_table_unit
package bnht_pkg;

  localparam int unsigned TABLE_SIZE = 1024;
  localparam int unsigned SLOT_W     = 10;
  localparam int unsigned FILL_W     = 11;
  localparam int unsigned KEY_W      = 64;
  localparam int unsigned CST_W      = 36;
  localparam int unsigned DLT_W      = 35;

  localparam logic [FILL_W-1:0] FILL_MAX   = 11'd2047;
  localparam logic [FILL_W-1:0] FILL_LIMIT = FILL_W'(TABLE_SIZE * 8 / 10);

  localparam logic [1:0] CMD_SEARCH = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;

  localparam logic [2:0] ST_FOUND    = 3'd0;
  localparam logic [2:0] ST_NOTFOUND = 3'd1;
  localparam logic [2:0] ST_INSERTED = 3'd2;
  localparam logic [2:0] ST_DELETED  = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  typedef enum logic [1:0] {
    TAG_EMPTY = 2'd0,
    TAG_USED  = 2'd1,
    TAG_DEAD  = 2'd2
  } tag_e;

  typedef struct packed {
    logic [15:0] var_index;
    logic [31:0] high_id;
    logic [31:0] low_id;
    logic [31:0] handle;
  } entry_t;

  typedef struct packed {
    logic              tag_we;
    logic              data_we;
    logic [SLOT_W-1:0] waddr;
    tag_e              tag;
    logic              rd_en;
    logic [SLOT_W-1:0] raddr;
  } store_req_t;

endpackage

### rtl/core/bdd_node_hash_table_unit.sv
// after reset a pass over every slot clears every tag before the first beat is taken
// a request runs the setup states S_PRE0 to S_PRE3, then S_HASH, S_READ and S_EVAL per probe
// (one 64-bit adder, one memory read); a request makes n = 1 .. PROBE_LIMIT+1 probes
// refused inserts and undefined commands skip the probes and answer in the cycle after accept; one request at a time
// input is ready again the cycle after the result beat is taken
// reset is asynchronous, active low; it clears control state and the fill count
module bdd_node_hash_table_unit import bnht_pkg::*; #(
  parameter int unsigned PROBE_LIMIT = 50
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // var_index[15:0], high_id[47:16], low_id[79:48], node_handle[111:80]
  input  logic [111:0] s_axis_tdata,
  // command[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // slot[9:0], found_handle[41:10], zero[47:42]
  output logic [47:0]  m_axis_tdata,
  // status[2:0]
  output logic [2:0]   m_axis_tuser
);

`include "assert_macros.svh"

  localparam int unsigned PW = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT + 1) : 1;
  localparam logic [PW-1:0] PROBE_LAST = PW'(PROBE_LIMIT);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_PRE0  = 4'd2;
  localparam logic [3:0] S_PRE1  = 4'd3;
  localparam logic [3:0] S_PRE2  = 4'd4;
  localparam logic [3:0] S_PRE3  = 4'd5;
  localparam logic [3:0] S_HASH  = 4'd6;
  localparam logic [3:0] S_READ  = 4'd7;
  localparam logic [3:0] S_EVAL  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]        state_q, state_d;
  logic [SLOT_W-1:0] clr_q, clr_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [PW-1:0]     probe_q, probe_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [CST_W-1:0]  cst_q, cst_d;
  logic [DLT_W-1:0]  dlt_q, dlt_d;
  logic [2:0]        status_q, status_d;
  logic [SLOT_W-1:0] oslot_q, oslot_d;
  logic [31:0]       found_q, found_d;

  logic [1:0]  cmd_q;
  entry_t      req_q;

  logic              accept;
  logic [KEY_W-1:0]  add_a, add_b, add_sum;
  logic [SLOT_W-1:0] hash_slot;
  store_req_t        st_req;
  tag_e              tag_rd;
  entry_t            ent_rd;

  assign accept = s_axis_tvalid && s_axis_tready;

  // payload of the accepted beat
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q           <= s_axis_tuser;
      req_q.var_index <= s_axis_tdata[15:0];
      req_q.high_id   <= s_axis_tdata[47:16];
      req_q.low_id    <= s_axis_tdata[79:48];
      req_q.handle    <= s_axis_tdata[111:80];
    end
  end

  // shared 64-bit adder
  always_comb begin
    add_a = '0;
    add_b = '0;
    case (state_q)
      S_PRE0: begin
        add_a = {31'd0, req_q.high_id, 1'b0};
        add_b = {32'd0, req_q.low_id};
      end
      S_PRE1: begin
        add_a = {28'd0, cst_q};
        add_b = {36'd0, req_q.high_id[31:4]};
      end
      S_PRE2: begin
        add_a = {28'd0, cst_q};
        add_b = {37'd0, req_q.low_id[31:5]};
      end
      S_PRE3: begin
        add_a = {32'd0, req_q.high_id};
        add_b = {31'd0, req_q.low_id, 1'b0};
      end
      S_HASH: begin
        add_a = key_q;
        add_b = {28'd0, cst_q};
      end
      S_READ: begin
        add_a = key_q;
        add_b = {key_q[KEY_W-3:0], 2'b00};
      end
      S_EVAL: begin
        add_a = key_q;
        add_b = {29'd0, dlt_q};
      end
      default: begin
        add_a = '0;
        add_b = '0;
      end
    endcase
  end

  assign add_sum = add_a + add_b;

  // negating a negative hash only needs its low bits for the slot
  assign hash_slot = add_sum[KEY_W-1] ? SLOT_W'(~add_sum[SLOT_W-1:0] + SLOT_W'(1))
                                      : add_sum[SLOT_W-1:0];

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    fill_d   = fill_q;
    probe_d  = probe_q;
    slot_d   = slot_q;
    key_d    = key_q;
    cst_d    = cst_q;
    dlt_d    = dlt_q;
    status_d = status_q;
    oslot_d  = oslot_q;
    found_d  = found_q;

    st_req.tag_we  = 1'b0;
    st_req.data_we = 1'b0;
    st_req.waddr   = slot_q;
    st_req.tag     = TAG_USED;
    st_req.rd_en   = (state_q == S_READ);
    st_req.raddr   = slot_q;

    case (state_q)
      S_CLEAR: begin
        st_req.tag_we = 1'b1;
        st_req.waddr  = clr_q;
        st_req.tag    = TAG_EMPTY;
        clr_d         = clr_q + SLOT_W'(1);
        if (clr_q == SLOT_W'(TABLE_SIZE - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          key_d    = {48'd0, s_axis_tdata[15:0]};
          probe_d  = '0;
          status_d = ST_FULL;
          oslot_d  = '0;
          found_d  = '0;
          state_d  = S_PRE0;
          if (s_axis_tuser == CMD_INSERT) begin
            if (fill_q != FILL_MAX) begin
              fill_d = fill_q + FILL_W'(1);
            end
            if (fill_q > FILL_LIMIT) begin
              state_d = S_DONE;
            end
          end else if (s_axis_tuser != CMD_SEARCH && s_axis_tuser != CMD_DELETE) begin
            status_d = ST_NOTFOUND;
            state_d  = S_DONE;
          end
        end
      end
      S_PRE0: begin
        cst_d   = add_sum[CST_W-1:0];
        state_d = S_PRE1;
      end
      S_PRE1: begin
        cst_d   = add_sum[CST_W-1:0];
        state_d = S_PRE2;
      end
      S_PRE2: begin
        cst_d   = add_sum[CST_W-1:0];
        state_d = S_PRE3;
      end
      S_PRE3: begin
        dlt_d   = add_sum[DLT_W-1:0];
        state_d = S_HASH;
      end
      S_HASH: begin
        slot_d  = hash_slot;
        state_d = S_READ;
      end
      S_READ: begin
        key_d   = add_sum;
        state_d = S_EVAL;
      end
      S_EVAL: begin
        key_d   = add_sum;
        state_d = S_DONE;
        if (cmd_q == CMD_INSERT) begin
          if (tag_rd != TAG_USED) begin
            st_req.tag_we  = 1'b1;
            st_req.data_we = 1'b1;
            st_req.tag     = TAG_USED;
            status_d       = ST_INSERTED;
            oslot_d        = slot_q;
          end else if (probe_q != PROBE_LAST) begin
            probe_d = probe_q + PW'(1);
            state_d = S_HASH;
          end
        end else begin
          case (tag_rd)
            TAG_EMPTY: begin
              status_d = ST_NOTFOUND;
            end
            TAG_USED: begin
              if (cmd_q == CMD_SEARCH && ent_rd.var_index == req_q.var_index &&
                  ent_rd.high_id == req_q.high_id && ent_rd.low_id == req_q.low_id) begin
                status_d = ST_FOUND;
                oslot_d  = slot_q;
                found_d  = ent_rd.handle;
              end else if (cmd_q == CMD_DELETE && ent_rd.handle == req_q.handle) begin
                st_req.tag_we = 1'b1;
                st_req.tag    = TAG_DEAD;
                status_d      = ST_DELETED;
                oslot_d       = slot_q;
              end else if (probe_q != PROBE_LAST) begin
                probe_d = probe_q + PW'(1);
                state_d = S_HASH;
              end
            end
            default: begin
              // tombstone: probe on
              if (probe_q != PROBE_LAST) begin
                probe_d = probe_q + PW'(1);
                state_d = S_HASH;
              end
            end
          endcase
        end
      end
      S_DONE: begin
        if (m_axis_tready) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      fill_q  <= '0;
      probe_q <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      fill_q  <= fill_d;
      probe_q <= probe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q   <= slot_d;
    key_q    <= key_d;
    cst_q    <= cst_d;
    dlt_q    <= dlt_d;
    status_q <= status_d;
    oslot_q  <= oslot_d;
    found_q  <= found_d;
  end

  bnht_store u_store (
    .clk_i   (clk_i),
    .req_i   (st_req),
    .wdata_i (req_q),
    .tag_o   (tag_rd),
    .data_o  (ent_rd)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_DONE);
  assign m_axis_tdata  = {6'd0, found_q, oslot_q};
  assign m_axis_tuser  = status_q;

  `BNHT_ASSERT(a_fill_monotone, clk_i, rst_ni, ##1 fill_q >= $past(fill_q))
  `BNHT_ASSERT(a_probe_bound, clk_i, rst_ni, probe_q <= PROBE_LAST)
  `BNHT_NEVER(a_handle_only_found, clk_i, rst_ni,
    m_axis_tvalid && status_q != ST_FOUND && found_q != 32'd0)
  `BNHT_NEVER(a_write_window, clk_i, rst_ni,
    st_req.tag_we && state_q != S_CLEAR && state_q != S_EVAL)

endmodule

### rtl/core/bnht_store.sv
// slot store: tag memory and entry memory, one write and one read port each
// depends on bnht_pkg
module bnht_store import bnht_pkg::*; (
  input  logic       clk_i,
  input  store_req_t req_i,
  input  entry_t     wdata_i,
  output tag_e       tag_o,
  output entry_t     data_o
);

  tag_e   tag_mem  [TABLE_SIZE];
  entry_t data_mem [TABLE_SIZE];
  tag_e   tag_q;
  entry_t data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.tag_we) begin
      tag_mem[req_i.waddr] <= req_i.tag;
    end
    if (req_i.rd_en) begin
      tag_q <= tag_mem[req_i.raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.data_we) begin
      data_mem[req_i.waddr] <= wdata_i;
    end
    if (req_i.rd_en) begin
      data_q <= data_mem[req_i.raddr];
    end
  end

  assign tag_o  = tag_q;
  assign data_o = data_q;

endmodule

### tb/bnht_checker.sv
// watches both streams of the node hash table, mirrors the table and checks every result beat
// depends on bnht_pkg for the tag, entry, command and status encodings
module bnht_checker import bnht_pkg::*; #(
  parameter int unsigned PROBE_LIMIT = 50
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         req_valid_i,
  input  logic         req_ready_i,
  // var_index[15:0], high_id[47:16], low_id[79:48], node_handle[111:80]
  input  logic [111:0] req_data_i,
  // command[1:0]
  input  logic [1:0]   req_cmd_i,
  input  logic         rsp_valid_i,
  input  logic         rsp_ready_i,
  // slot[9:0], found_handle[41:10], zero[47:42]
  input  logic [47:0]  rsp_data_i,
  // status[2:0]
  input  logic [2:0]   rsp_status_i,
  output int           fail_count_o,
  output int           outstanding_o,
  output int           found_o,
  output int           missed_o,
  output int           inserted_o,
  output int           deleted_o,
  output int           refused_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]        status;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       handle;
  } node_answer_t;

  // mirror of the table
  tag_e              slot_state [TABLE_SIZE];
  entry_t            slot_node  [TABLE_SIZE];
  logic [FILL_W-1:0] insert_attempts;

  node_answer_t pending_answers[$];
  entry_t       req_node;
  node_answer_t want;

  initial begin
    foreach (slot_state[i]) slot_state[i] = TAG_EMPTY;
    insert_attempts = '0;
    fail_count_o = 0;
    outstanding_o = 0;
    found_o = 0;
    missed_o = 0;
    inserted_o = 0;
    deleted_o = 0;
    refused_o = 0;
  end

  function automatic logic [SLOT_W-1:0] probe_slot(logic [63:0] key, logic [63:0] hi,
                                                   logic [63:0] lo);
    logic [63:0] h;
    h = key + (hi << 1) + lo + (hi >> 4) + (lo >> 5);
    if (h[63]) h = -h;
    return SLOT_W'(h % TABLE_SIZE);
  endfunction

  function automatic logic [63:0] rehash(logic [63:0] key, logic [63:0] hi, logic [63:0] lo);
    return key + (key << 2) + hi + (lo << 1);
  endfunction

  // walks the probe sequence of one request, updates the mirror and returns the answer
  task automatic table_answer(input logic [1:0] cmd, input entry_t req,
                              output node_answer_t ans);
    logic [63:0]       key;
    logic [63:0]       hi;
    logic [63:0]       lo;
    logic [SLOT_W-1:0] s;
    logic              refuse;
    logic              done;
    ans = '{status: ST_FULL, slot: '0, handle: '0};
    key = 64'(req.var_index);
    hi = 64'(req.high_id);
    lo = 64'(req.low_id);
    done = 1'b0;
    case (cmd)
      CMD_INSERT: begin
        refuse = insert_attempts > FILL_LIMIT;
        if (insert_attempts < FILL_MAX) insert_attempts = insert_attempts + FILL_W'(1);
        for (int p = 0; p <= PROBE_LIMIT && !refuse && !done; p++) begin
          s = probe_slot(key, hi, lo);
          if (slot_state[s] != TAG_USED) begin
            slot_state[s] = TAG_USED;
            slot_node[s] = req;
            ans.status = ST_INSERTED;
            ans.slot = s;
            done = 1'b1;
          end else begin
            key = rehash(key, hi, lo);
          end
        end
      end
      CMD_SEARCH, CMD_DELETE: begin
        for (int p = 0; p <= PROBE_LIMIT && !done; p++) begin
          s = probe_slot(key, hi, lo);
          if (slot_state[s] == TAG_EMPTY) begin
            ans.status = ST_NOTFOUND;
            done = 1'b1;
          end else if (slot_state[s] == TAG_USED) begin
            if (cmd == CMD_SEARCH) begin
              if (slot_node[s].var_index == req.var_index &&
                  slot_node[s].high_id == req.high_id &&
                  slot_node[s].low_id == req.low_id) begin
                ans.status = ST_FOUND;
                ans.slot = s;
                ans.handle = slot_node[s].handle;
                done = 1'b1;
              end
            end else if (slot_node[s].handle == req.handle) begin
              slot_state[s] = TAG_DEAD;
              ans.status = ST_DELETED;
              ans.slot = s;
              done = 1'b1;
            end
          end
          // tombstones and non-matching entries fall through to the next probe
          if (!done) key = rehash(key, hi, lo);
        end
      end
      default: ans.status = ST_NOTFOUND;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
    if (fail_count_o < 40)
      $display("%0d ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, exp_val);
    fail_count_o++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_valid_i && req_ready_i) begin
        req_node.var_index = req_data_i[15:0];
        req_node.high_id = req_data_i[47:16];
        req_node.low_id = req_data_i[79:48];
        req_node.handle = req_data_i[111:80];
        table_answer(req_cmd_i, req_node, want);
        pending_answers.push_back(want);
      end
      if (rsp_valid_i && rsp_ready_i) begin
        if (pending_answers.size() == 0) begin
          report_mismatch("result beat with no request outstanding", 64'(rsp_status_i), '0);
        end else begin
          want = pending_answers.pop_front();
          if (rsp_status_i !== want.status)
            report_mismatch("status", 64'(rsp_status_i), 64'(want.status));
          if (rsp_data_i[9:0] !== want.slot)
            report_mismatch("slot", 64'(rsp_data_i[9:0]), 64'(want.slot));
          if (rsp_data_i[41:10] !== want.handle)
            report_mismatch("found_handle", 64'(rsp_data_i[41:10]), 64'(want.handle));
          if (rsp_data_i[47:42] !== '0)
            report_mismatch("tdata padding", 64'(rsp_data_i[47:42]), '0);
          case (want.status)
            ST_FOUND:    found_o++;
            ST_NOTFOUND: missed_o++;
            ST_INSERTED: inserted_o++;
            ST_DELETED:  deleted_o++;
            default:     refused_o++;
          endcase
        end
      end
      outstanding_o = pending_answers.size();
    end
  end

endmodule

### tb/bdd_node_hash_table_unit_tb.sv
// top of the node hash table testbench: clock, reset, request stimulus and result sink
// depends on bnht_pkg, bdd_node_hash_table_unit and bnht_checker
module bdd_node_hash_table_unit_tb import bnht_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PROBE_LIMIT = 50;
  localparam int RANDOM_ITEMS = 1500;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 200;
  localparam logic [1:0] CMD_UNDEF = 2'd3;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [47:0]  m_axis_tdata;
  logic [2:0]   m_axis_tuser;

  int fail_count;
  int outstanding;
  int n_found;
  int n_missed;
  int n_inserted;
  int n_deleted;
  int n_refused;

  int     n_sent = 0;
  int     insert_sent = 0;
  int     n_chains = 0;
  int     src_quiet = 0;
  entry_t node_pool[$];

  bdd_node_hash_table_unit #(
    .PROBE_LIMIT(PROBE_LIMIT)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  bnht_checker #(
    .PROBE_LIMIT(PROBE_LIMIT)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_i  (s_axis_tready),
    .req_data_i   (s_axis_tdata),
    .req_cmd_i    (s_axis_tuser),
    .rsp_valid_i  (m_axis_tvalid),
    .rsp_ready_i  (m_axis_tready),
    .rsp_data_i   (m_axis_tdata),
    .rsp_status_i (m_axis_tuser),
    .fail_count_o (fail_count),
    .outstanding_o(outstanding),
    .found_o      (n_found),
    .missed_o     (n_missed),
    .inserted_o   (n_inserted),
    .deleted_o    (n_deleted),
    .refused_o    (n_refused)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic entry_t make_node(logic [15:0] v, logic [31:0] hi, logic [31:0] lo,
                                       logic [31:0] hnd);
    entry_t e;
    e.var_index = v;
    e.high_id = hi;
    e.low_id = lo;
    e.handle = hnd;
    return e;
  endfunction

  function automatic logic [31:0] pick_child();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return 32'($urandom_range(0, 31));
    if (r < 18) return '1;
    return $urandom;
  endfunction

  function automatic entry_t fresh_node();
    entry_t e;
    e.var_index = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 7)) : 16'($urandom);
    e.high_id = pick_child();
    e.low_id = pick_child();
    e.handle = $urandom;
    return e;
  endfunction

  // mostly short gaps, a few long ones, and stretches with none
  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (src_quiet > 0) begin
      src_quiet--;
      return 0;
    end
    if (r < 3) begin
      src_quiet = $urandom_range(30, 200);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic issue(input logic [1:0] cmd, input entry_t e);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tuser <= cmd;
    s_axis_tdata <= {e.handle, e.low_id, e.high_id, e.var_index};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    n_sent++;
    if (cmd == CMD_INSERT) insert_sent++;
  endtask

  task automatic insert_random();
    entry_t e;
    if (node_pool.size() > 0 && $urandom_range(0, 99) < 12)
      e = node_pool[$urandom_range(0, node_pool.size() - 1)];
    else
      e = fresh_node();
    e.handle = $urandom;
    node_pool.push_back(e);
    issue(CMD_INSERT, e);
  endtask

  task automatic search_random();
    entry_t e;
    int r;
    r = $urandom_range(0, 99);
    if (node_pool.size() == 0 || r >= 80) begin
      e = fresh_node();
    end else begin
      e = node_pool[$urandom_range(0, node_pool.size() - 1)];
      // near miss: one key bit off
      if (r >= 60) begin
        case ($urandom_range(0, 2))
          0:       e.var_index ^= 16'(1) << $urandom_range(0, 15);
          1:       e.high_id ^= 32'(1) << $urandom_range(0, 31);
          default: e.low_id ^= 32'(1) << $urandom_range(0, 31);
        endcase
      end
    end
    e.handle = $urandom;
    issue(CMD_SEARCH, e);
  endtask

  task automatic delete_random();
    entry_t e;
    int idx;
    int r;
    r = $urandom_range(0, 99);
    if (node_pool.size() == 0 || r >= 85) begin
      e = fresh_node();
    end else begin
      idx = $urandom_range(0, node_pool.size() - 1);
      e = node_pool[idx];
      if (r < 65) begin
        if ($urandom_range(0, 4) != 0) node_pool.delete(idx);
      end else begin
        e.handle = $urandom;
      end
    end
    issue(CMD_DELETE, e);
  endtask

  // same key inserted many times builds one long probe chain, up to the probe limit
  task automatic run_chain();
    entry_t base;
    entry_t links[$];
    int     n;
    base = fresh_node();
    n = $urandom_range(20, 55);
    n_chains++;
    repeat (n) begin
      base.handle = $urandom;
      links.push_back(base);
      node_pool.push_back(base);
      issue(CMD_INSERT, base);
    end
    issue(CMD_SEARCH, base);
    repeat ($urandom_range(2, 6)) issue(CMD_DELETE, links[$urandom_range(0, links.size() - 1)]);
    issue(CMD_SEARCH, base);
  endtask

  initial begin
    int     r;
    int     random_end;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = CMD_SEARCH;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // key (0,0,0) hashes to slot 0 and rehashes to itself forever
    issue(CMD_SEARCH, make_node(0, 0, 0, 0));
    issue(CMD_DELETE, make_node(0, 0, 0, 0));
    issue(CMD_UNDEF, make_node(0, 0, 0, 0));
    issue(CMD_INSERT, make_node(0, 0, 0, 32'h1111_0001));
    issue(CMD_SEARCH, make_node(0, 0, 0, 32'h5555_aaaa));
    issue(CMD_INSERT, make_node(0, 0, 0, 32'h2222_0002));
    issue(CMD_INSERT, make_node('1, '1, '1, '1));
    issue(CMD_SEARCH, make_node('1, '1, '1, 0));
    issue(CMD_SEARCH, make_node(16'hfffe, '1, '1, 0));
    issue(CMD_DELETE, make_node(0, 0, 0, 32'h0bad_0bad));
    issue(CMD_DELETE, make_node(0, 0, 0, 32'h1111_0001));
    issue(CMD_SEARCH, make_node(0, 0, 0, 0));
    issue(CMD_DELETE, make_node(0, 0, 0, 32'h1111_0001));
    issue(CMD_INSERT, make_node(0, 0, 0, 0));
    issue(CMD_SEARCH, make_node(0, 0, 0, '1));
    issue(CMD_UNDEF, make_node('1, '1, '1, '1));
    issue(CMD_DELETE, make_node('1, '1, '1, '1));
    issue(CMD_SEARCH, make_node('1, '1, '1, 0));
    issue(CMD_INSERT, make_node(16'h8000, 0, '1, 32'h8000_0000));
    issue(CMD_INSERT, make_node(16'h0001, '1, 0, 32'h0000_0001));
    issue(CMD_SEARCH, make_node(16'h8000, 0, '1, 0));

    random_end = n_sent + RANDOM_ITEMS;
    while (n_sent < random_end) begin
      r = $urandom_range(0, 999);
      if (r < 15 && insert_sent < 650) run_chain();
      else if (r < 365) insert_random();
      else if (r < 715) search_random();
      else if (r < 965) delete_random();
      else issue(CMD_UNDEF, fresh_node());
    end

    // push the insert counter past the fill limit, refused inserts answer without probing
    while (insert_sent <= int'(FILL_LIMIT) + 16) begin
      if ($urandom_range(0, 99) < 85) insert_random();
      else if ($urandom_range(0, 1) == 0) search_random();
      else delete_random();
    end
    s_axis_tvalid <= 1'b0;

    while (outstanding != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("covered %0d requests: %0d insert attempts, %0d same-key probe chains",
             n_sent, insert_sent, n_chains);
    $display("answers seen: %0d found, %0d missed, %0d inserted, %0d deleted, %0d refused",
             n_found, n_missed, n_inserted, n_deleted, n_refused);
    if (fail_count == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // result sink with random back-pressure
  initial begin
    int stall_left;
    int quiet_left;
    int r;
    stall_left = 0;
    quiet_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (quiet_left > 0) quiet_left--;
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        r = $urandom_range(0, 99);
        if (quiet_left == 0) begin
          if (r < 2) quiet_left = $urandom_range(40, 300);
          else if (r < 6) stall_left = $urandom_range(8, 40);
          else if (r < 30) stall_left = $urandom_range(1, 3);
        end
      end
    end
  end

  // ends the run when no beat moves on either side for too long
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("watchdog: no beat for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, outstanding);
    $display("TEST FAILED");
    $finish;
  end

endmodule
